// ----- sv/moving_average_window_macros.svh -----
// Assertion macros shared by the RTL files of the moving average block.
// In synthesis the macros expand to nothing.
`ifndef MOVING_AVERAGE_WINDOW_MACROS_SVH
`define MOVING_AVERAGE_WINDOW_MACROS_SVH

`ifndef SYNTHESIS

`define MAVW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("moving average check failed");

`define MAVW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("moving average check failed");

`else

`define MAVW_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define MAVW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/mavw_pkg.sv -----
`timescale 1ns / 1ps

package mavw_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W = 42;
    localparam int LEN_W = 11;
    localparam int DIV_STEPS = SUM_W;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(20);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_UPDATE = 6'b000100,
        ST_PREP   = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    typedef struct packed {
        logic capture;
        logic read;
        logic update;
        logic prep;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

// ----- sv/mavw_datapath.sv -----
`timescale 1ns / 1ps
`include "moving_average_window_macros.svh"

module mavw_datapath #(
    parameter int MAX_WINDOW = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mavw_pkg::LEN_W-1:0]       cfg_wr_data,
    input  logic signed [mavw_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                             s_first,
    input  mavw_pkg::cmd_t                   cmd,
    output mavw_pkg::status_t                status,
    output logic signed [mavw_pkg::SAMPLE_W-1:0] m_average,
    output logic                             m_ready_res
);
    import mavw_pkg::*;

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SEEN_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
    localparam int CMP_W = (SEEN_W > LEN_W) ? SEEN_W : LEN_W;

    logic [LEN_W-1:0]    window_length_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_eff;
    logic [PTR_W-1:0]    wp_reg;
    logic [PTR_W-1:0]    wp_next;
    logic [PTR_W-1:0]    old_idx;
    logic [IDX_W-1:0]    wp_ext;
    logic [IDX_W-1:0]    len_ext;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SEEN_W-1:0]   seen_reg;
    logic [SEEN_W-1:0]   seen_next;
    logic                seen_full;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] ring [MAX_WINDOW];
    logic                ready_reg;
    logic                neg_reg;
    logic [SUM_W-1:0]    quot_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [LEN_W:0]      rem_shift;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SAMPLE_W-1:0] avg_sat;
    logic [SAMPLE_W-1:0] avg_reg;
    logic                ready_out_reg;

    always_comb begin
        if (window_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (int'(window_length_reg) > MAX_WINDOW) begin
            len_eff = LEN_W'(MAX_WINDOW);
        end else begin
            len_eff = window_length_reg;
        end
    end

    assign wp_ext = IDX_W'(wp_reg);
    assign len_ext = IDX_W'(len_reg);

    always_comb begin
        if (wp_ext >= len_ext) begin
            old_idx = PTR_W'(wp_ext - len_ext);
        end else begin
            old_idx = PTR_W'(wp_ext + IDX_W'(MAX_WINDOW) - len_ext);
        end
    end

    assign seen_full = CMP_W'(seen_reg) >= CMP_W'(len_reg);

    always_comb begin
        sum_next = sum_reg + {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
        if (seen_full) begin
            sum_next = sum_next - {{(SUM_W-SAMPLE_W){rd_data_reg[SAMPLE_W-1]}}, rd_data_reg};
        end
    end

    assign seen_next = (seen_reg == SEEN_W'(MAX_WINDOW)) ? seen_reg : seen_reg + SEEN_W'(1);
    assign wp_next = (int'(wp_reg) == MAX_WINDOW - 1) ? '0 : wp_reg + PTR_W'(1);

    assign rem_shift = {rem_reg, quot_reg[SUM_W-1]};

    always_comb begin
        if (neg_reg) begin
            if (quot_reg[SUM_W-1:SAMPLE_W] != '0
                    || (quot_reg[SAMPLE_W-1] && quot_reg[SAMPLE_W-2:0] != '0)) begin
                avg_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
            end else begin
                avg_sat = SAMPLE_W'(0) - quot_reg[SAMPLE_W-1:0];
            end
        end else if (quot_reg[SUM_W-1:SAMPLE_W-1] != '0) begin
            avg_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            avg_sat = quot_reg[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WINDOW_RESET;
            wp_reg <= '0;
            sum_reg <= '0;
            seen_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                window_length_reg <= cfg_wr_data;
            end
            if (cmd.capture && s_first) begin
                sum_reg <= '0;
                seen_reg <= '0;
            end
            if (cmd.update) begin
                sum_reg <= sum_next;
                seen_reg <= seen_next;
                wp_reg <= wp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_sample;
            len_reg <= len_eff;
        end
        if (cmd.read) begin
            rd_data_reg <= ring[old_idx];
        end
        if (cmd.update) begin
            ring[wp_reg] <= sample_reg;
            ready_reg <= CMP_W'(seen_next) >= CMP_W'(len_reg);
        end
        if (cmd.prep) begin
            neg_reg <= sum_reg[SUM_W-1];
            quot_reg <= sum_reg[SUM_W-1] ? SUM_W'(0) - sum_reg : sum_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (rem_shift >= {1'b0, len_reg}) begin
                rem_reg <= LEN_W'(rem_shift - {1'b0, len_reg});
                quot_reg <= {quot_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[LEN_W-1:0];
                quot_reg <= {quot_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.load_out) begin
            avg_reg <= ready_reg ? avg_sat : '0;
            ready_out_reg <= ready_reg;
        end
    end

    assign status.div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign m_average = avg_reg;
    assign m_ready_res = ready_out_reg;

    `MAVW_ASSERT_SAME(a_div_in_range, aclk, aresetn, cmd.div_step,
        int'(cnt_reg) < DIV_STEPS)
    `MAVW_ASSERT_SAME(a_len_legal, aclk, aresetn, cmd.update,
        len_reg != '0 && int'(len_reg) <= MAX_WINDOW)
    `MAVW_ASSERT_SAME(a_rem_below_len, aclk, aresetn, cmd.div_step, rem_reg < len_reg)

endmodule

// ----- sv/mavw_ctrl.sv -----
`timescale 1ns / 1ps
`include "moving_average_window_macros.svh"

module mavw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  mavw_pkg::status_t   status,
    output mavw_pkg::cmd_t      cmd
);
    import mavw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MAVW_ASSERT_NEXT(a_accept_starts_read, aclk, aresetn, s_tvalid && s_tready,
        state_reg == ST_READ)
    `MAVW_ASSERT_NEXT(a_div_ends_in_out, aclk, aresetn,
        state_reg == ST_DIV && status.div_last, state_reg == ST_OUT)
    `MAVW_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.load_out,
        !out_valid_reg || m_tready)
    `MAVW_ASSERT_NEXT(a_load_shows_beat, aclk, aresetn, cmd.load_out, m_tvalid)

endmodule

// ----- sv/moving_average_window.sv -----
`timescale 1ns / 1ps
// Channel   Direction  tdata                 tuser
// s_*       in         [31:0] sample         [0] first_of_series
// m_*       out        [31:0] average        [0] ready_res
//
// Each beat passes from acceptance through reading the ring and updating the sum, the
// shift-subtract divider with one quotient bit per cycle, and the load of the output
// register. The next beat is accepted only once the output register has been loaded.
// Reset is synchronous and active low; the ring memory needs no clearing pass.
// A finished result waits in the output register, so the next beat is accepted
// while it is stalled; a second result waits until the first one is taken.

module moving_average_window #(
    parameter int MAX_WINDOW = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    input  logic [0:0]  s_tuser,   // [0] first_of_series
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] average
    output logic [0:0]  m_tuser    // [0] ready_res
);
    import mavw_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic signed [SAMPLE_W-1:0] average;
    logic    ready_res;

    mavw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mavw_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_sample    (s_tdata),
        .s_first     (s_tuser[0]),
        .cmd         (cmd),
        .status      (status),
        .m_average   (average),
        .m_ready_res (ready_res)
    );

    assign m_tdata = average;
    assign m_tuser = ready_res;

endmodule
